/* sv/text_console_writer_defines.svh */
// Assertion macros for the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checks a condition at the same clock edge as its trigger.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Checks a condition at the clock edge after its trigger.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCW_ASSERT_NOW(lbl, ante, cons, msg)
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/tcw_pkg.sv */
// Package with the geometry, codes and shared types of the text console writer.
package tcw_pkg;

    // Screen geometry.
    localparam int unsigned COLUMNS    = 80;
    localparam int unsigned ROWS       = 25;
    localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
    localparam int unsigned CELL_AW    = $clog2(CELL_COUNT);
    localparam int unsigned COL_W      = $clog2(COLUMNS);
    localparam int unsigned ROW_W      = (ROWS > 2) ? $clog2(ROWS) : 1;

    // Port field widths.
    localparam int unsigned POS_W  = 11;
    localparam int unsigned ARG_W  = 16;
    localparam int unsigned CELL_W = 16;
    localparam int unsigned COLOR_W = 4;

    // Row number by reciprocal multiplication: floor(x / COLUMNS) for x < 2**CELL_AW.
    localparam int unsigned DIV_SHIFT = CELL_AW + $clog2(COLUMNS);
    localparam int unsigned RECIP     = (2 ** DIV_SHIFT + COLUMNS - 1) / COLUMNS;
    localparam int unsigned PROD_W    = 2 * CELL_AW + 1;

    localparam int unsigned TAB_STEP = 4;
    localparam logic [CELL_W-1:0]  CLEAR_CELL  = 16'h0720;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 4'd15;
    localparam int unsigned        MAX_COLOR   = 15;

    // Control characters.
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;

    // Command codes.
    typedef enum logic [2:0] {
        OP_PUT_CHAR      = 3'd0,
        OP_FLUSH         = 3'd1,
        OP_CLEAR         = 3'd2,
        OP_SET_COLOR     = 3'd3,
        OP_RESTORE_COLOR = 3'd4,
        OP_SET_POS       = 3'd5
    } t_opcode;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POS_DIV,
        ST_POS_MUL,
        ST_CLEAR
    } t_state;

    // One write into the cell store.
    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] addr;
        logic [CELL_W-1:0]  data;
    } t_cell_wr;

    // Progress of the clearing sweep.
    typedef struct packed {
        logic active;
        logic last;
    } t_sweep_status;

endpackage

/* sv/tcw_cell_store.sv */
// Text cell memory with its clearing sweep engine.
module tcw_cell_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tcw_pkg::t_cell_wr      i_wr,
    input  logic                   i_clear_start,
    output tcw_pkg::t_sweep_status o_sweep
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_cells [CELL_COUNT];

    logic               r_sweeping;
    logic [CELL_AW-1:0] r_sweep_addr;
    logic               w_last;
    logic               w_we;
    logic [CELL_AW-1:0] w_addr;
    logic [CELL_W-1:0]  w_data;

    assign w_last = r_sweeping && (r_sweep_addr == CELL_AW'(CELL_COUNT - 1));

    // The sweep owns the write port while it runs.
    assign w_we   = r_sweeping || i_wr.en;
    assign w_addr = r_sweeping ? r_sweep_addr : i_wr.addr;
    assign w_data = r_sweeping ? CLEAR_CELL : i_wr.data;

    // Sweep counter: one cell per cycle from the first to the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweeping   <= 1'b0;
            r_sweep_addr <= '0;
        end else if (i_clear_start) begin
            r_sweeping   <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_sweeping) begin
            if (w_last) begin
                r_sweeping <= 1'b0;
            end
            r_sweep_addr <= r_sweep_addr + 1'b1;
        end
    end

    // Cell memory write port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cells[w_addr] <= w_data;
        end
    end

    assign o_sweep.active = r_sweeping;
    assign o_sweep.last   = w_last;

endmodule

/* sv/text_console_writer.sv */
// Top level of the text console writer: command sequencer, cursor and color state.
//
// Channel   | Handshake                | Payload
// ----------+--------------------------+----------------------------------------------
// command   | start in, busy out       | i_opcode, i_arg_value
// result    | o_result_valid strobe    | o_status, o_cursor_pos, o_cursor_load,
//           |                          | o_cell_written, o_cell_addr, o_cell_value,
//           |                          | o_screen_cleared
// config    | i_cfg_we                 | i_cfg_wdata (default color)
//
// For most commands the result strobes in the cycle after the transfer and busy stays
// low, so a command may follow in every cycle.
// Set position holds busy through the reciprocal multiply and then the row start step,
// and its result is registered in the row start step rather than at the transfer.
// A clear, or a cursor that runs off the end, holds busy high while the store is swept
// from the first cell to the last; the result strobes at once.
// Reset sets the cursor to 0 and both colors to white; the cell store is not cleared.
// The receiver cannot stall: every result lasts exactly one cycle.
`include "text_console_writer_defines.svh"

module text_console_writer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_opcode,
    input  logic [tcw_pkg::ARG_W-1:0]    i_arg_value,
    input  logic                         i_cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0]  i_cfg_wdata,
    output logic                         o_result_valid,
    output logic                         o_status,
    output logic [tcw_pkg::POS_W-1:0]    o_cursor_pos,
    output logic                         o_cursor_load,
    output logic                         o_cell_written,
    output logic [tcw_pkg::POS_W-1:0]    o_cell_addr,
    output logic [tcw_pkg::CELL_W-1:0]   o_cell_value,
    output logic                         o_screen_cleared
);
    import tcw_pkg::*;

    // State registers and their next values.
    t_state              r_state,  n_state;
    logic [CELL_AW-1:0]  r_cursor, n_cursor;
    logic [COL_W-1:0]    r_col,    n_col;
    logic [COLOR_W-1:0]  r_color,  n_color;
    logic [COLOR_W-1:0]  r_default;
    logic [CELL_AW-1:0]  r_arg,    n_arg;
    logic [ROW_W-1:0]    r_quot,   n_quot;

    // Result registers.
    logic                r_res_valid,   n_res_valid;
    logic                r_res_status,  n_res_status;
    logic [POS_W-1:0]    r_res_cursor,  n_res_cursor;
    logic                r_res_load,    n_res_load;
    logic                r_res_written, n_res_written;
    logic [POS_W-1:0]    r_res_addr,    n_res_addr;
    logic [CELL_W-1:0]   r_res_value,   n_res_value;
    logic                r_res_cleared, n_res_cleared;

    // Working signals.
    logic                w_accept;
    logic [7:0]          w_char;
    logic [CELL_AW-1:0]  w_row_base;
    logic [CELL_AW:0]    w_move;
    logic [COL_W:0]      w_col_sum;
    logic [PROD_W-1:0]   w_prod;
    logic [CELL_AW-1:0]  w_pos_base;
    t_cell_wr            w_wr;
    logic                w_clear_start;
    t_sweep_status       w_sweep;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_char   = i_arg_value[7:0];

    // Start of the cursor's row, from the tracked column.
    assign w_row_base = r_cursor - CELL_AW'(r_col);

    // Row number of a requested position and the start of that row.
    assign w_prod     = PROD_W'(r_arg) * PROD_W'(RECIP);
    assign w_pos_base = CELL_AW'(r_quot * COLUMNS);

    tcw_cell_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (w_wr),
        .i_clear_start (w_clear_start),
        .o_sweep       (w_sweep)
    );

    // Next state, cursor movement and result.
    always_comb begin
        n_state       = r_state;
        n_cursor      = r_cursor;
        n_col         = r_col;
        n_color       = r_color;
        n_arg         = r_arg;
        n_quot        = r_quot;
        n_res_valid   = 1'b0;
        n_res_status  = 1'b0;
        n_res_cursor  = POS_W'(r_cursor);
        n_res_load    = 1'b0;
        n_res_written = 1'b0;
        n_res_addr    = '0;
        n_res_value   = '0;
        n_res_cleared = 1'b0;
        w_move        = '0;
        w_col_sum     = '0;
        w_wr.en       = 1'b0;
        w_wr.addr     = r_cursor;
        w_wr.data     = {{(CELL_W - COLOR_W - 8){1'b0}}, r_color, w_char};
        w_clear_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res_valid = 1'b1;
                    unique case (t_opcode'(i_opcode))
                        OP_PUT_CHAR: begin
                            priority if (w_char == CH_NEWLINE) begin
                                w_move = (CELL_AW + 1)'(w_row_base) + (CELL_AW + 1)'(COLUMNS);
                                n_col  = '0;
                            end else if (w_char == CH_TAB) begin
                                w_move    = (CELL_AW + 1)'(r_cursor) + (CELL_AW + 1)'(TAB_STEP);
                                w_col_sum = (COL_W + 1)'(r_col) + (COL_W + 1)'(TAB_STEP);
                                if (32'(w_col_sum) >= COLUMNS) begin
                                    n_col = COL_W'(w_col_sum - (COL_W + 1)'(COLUMNS));
                                end else begin
                                    n_col = COL_W'(w_col_sum);
                                end
                            end else if (w_char == CH_RETURN) begin
                                w_move = (CELL_AW + 1)'(w_row_base);
                                n_col  = '0;
                            end else begin
                                // Printable character: store it at the cursor.
                                w_wr.en       = 1'b1;
                                n_res_written = 1'b1;
                                n_res_addr    = POS_W'(r_cursor);
                                n_res_value   = w_wr.data;
                                w_move        = (CELL_AW + 1)'(r_cursor) + 1'b1;
                                if (32'(r_col) == COLUMNS - 1) begin
                                    n_col = '0;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                            // Running off the end of the screen clears it.
                            if (32'(w_move) >= CELL_COUNT) begin
                                n_cursor      = '0;
                                n_col         = '0;
                                n_res_cleared = 1'b1;
                                w_clear_start = 1'b1;
                                n_state       = ST_CLEAR;
                            end else begin
                                n_cursor = w_move[CELL_AW-1:0];
                            end
                            n_res_cursor = POS_W'(n_cursor);
                        end
                        OP_FLUSH: begin
                            n_res_load = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_cursor      = '0;
                            n_col         = '0;
                            n_res_cursor  = '0;
                            n_res_cleared = 1'b1;
                            w_clear_start = 1'b1;
                            n_state       = ST_CLEAR;
                        end
                        OP_SET_COLOR: begin
                            if (32'(i_arg_value) > MAX_COLOR) begin
                                n_res_status = 1'b1;
                            end else begin
                                n_color = i_arg_value[COLOR_W-1:0];
                            end
                        end
                        OP_RESTORE_COLOR: begin
                            n_color = r_default;
                        end
                        OP_SET_POS: begin
                            if (32'(i_arg_value) >= CELL_COUNT) begin
                                n_res_status = 1'b1;
                            end else begin
                                // The result waits for the row number.
                                n_res_valid = 1'b0;
                                n_arg       = i_arg_value[CELL_AW-1:0];
                                n_state     = ST_POS_DIV;
                            end
                        end
                        default: begin
                            n_res_status = 1'b1;
                        end
                    endcase
                end
            end
            ST_POS_DIV: begin
                n_quot  = w_prod[DIV_SHIFT +: ROW_W];
                n_state = ST_POS_MUL;
            end
            ST_POS_MUL: begin
                n_cursor     = r_arg;
                n_col        = COL_W'(r_arg - w_pos_base);
                n_res_valid  = 1'b1;
                n_res_cursor = POS_W'(r_arg);
                n_state      = ST_IDLE;
            end
            ST_CLEAR: begin
                if (w_sweep.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Cursor, colors and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_col       <= '0;
            r_color     <= RESET_COLOR;
            r_default   <= RESET_COLOR;
            r_res_valid <= 1'b0;
        end else begin
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_color     <= n_color;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_default <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_arg         <= n_arg;
        r_quot        <= n_quot;
        r_res_status  <= n_res_status;
        r_res_cursor  <= n_res_cursor;
        r_res_load    <= n_res_load;
        r_res_written <= n_res_written;
        r_res_addr    <= n_res_addr;
        r_res_value   <= n_res_value;
        r_res_cleared <= n_res_cleared;
    end

    assign o_result_valid   = r_res_valid;
    assign o_status         = r_res_status;
    assign o_cursor_pos     = r_res_cursor;
    assign o_cursor_load    = r_res_load;
    assign o_cell_written   = r_res_written;
    assign o_cell_addr      = r_res_addr;
    assign o_cell_value     = r_res_value;
    assign o_screen_cleared = r_res_cleared;

    // The cursor and its column always stay on the screen.
    `TCW_ASSERT_NOW(a_cursor_range, 1'b1,
        (32'(r_cursor) < CELL_COUNT) && (32'(r_col) < COLUMNS), "cursor off screen")
    // A clear command reports at once and then holds the block busy for the sweep.
    `TCW_ASSERT_NEXT(a_clear_busy, w_accept && (i_opcode == OP_CLEAR),
        o_result_valid && o_screen_cleared && busy && w_sweep.active, "clear not started")
    // The row number step is always followed by the row start step.
    `TCW_ASSERT_NEXT(a_pos_steps, r_state == ST_POS_DIV,
        r_state == ST_POS_MUL && !o_result_valid, "set position sequence broken")
    // The sweep runs exactly while the block waits in the clear state.
    `TCW_ASSERT_NOW(a_sweep_state, w_sweep.active, r_state == ST_CLEAR,
        "sweep outside clear state")

endmodule
